/* rtl/core/sapf_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sapf_pkg
// Shared types and constants of the steering angle PD force block.
// ---------------------------------------------------------------------------
package sapf_pkg;

  // Default full-scale wheel angle in degrees
  localparam int unsigned MAX_ANGLE_DEG_DEF = 120;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam logic [CFG_IDX_W-1:0] REG_AXIS_CENTER      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AXIS_HALF_RANGE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_LIMIT      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND_DEADBAND = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_US       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT_WHEEL     = 3'd7;

  // Register reset values
  localparam logic [14:0] RST_AXIS_CENTER      = 15'd0;
  localparam logic [14:0] RST_AXIS_HALF_RANGE  = 15'd10000;
  localparam logic [15:0] RST_PROP_GAIN        = 16'd4608;
  localparam logic [15:0] RST_DERIV_GAIN       = 16'd115;
  localparam logic [13:0] RST_FORCE_LIMIT      = 14'd3333;
  localparam logic [14:0] RST_COMMAND_DEADBAND = 15'd983;
  localparam logic [19:0] RST_TIMEOUT_US       = 20'd500000;

  // Command timer and tick length
  localparam logic [19:0] TIMER_MAX     = 20'hFFFFF;
  localparam logic [19:0] DT_DEFAULT_US = 20'd10000;

  // Smoothing weights (Q0.15) and rounding offset
  localparam logic signed [32:0] SMOOTH_OLD  = 33'sd27853;
  localparam logic signed [32:0] SMOOTH_NEW  = 33'sd4915;
  localparam logic signed [32:0] SMOOTH_HALF = 33'sd16384;

  // Microseconds per second for the damping term
  localparam logic signed [20:0] US_PER_S = 21'sd1000000;

  // Shared divider: numerator, divisor and quotient widths
  localparam int unsigned DIV_NW = 53;
  localparam int unsigned DIV_DW = 36;
  localparam int unsigned DIV_QW = 15;

  typedef struct packed {
    logic [14:0] axis_center;
    logic [14:0] axis_half_range;
    logic [15:0] prop_gain;
    logic [15:0] deriv_gain;
    logic [13:0] force_limit;
    logic [14:0] command_deadband;
    logic [19:0] timeout_us;
    logic        invert_wheel;
  } sapf_cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic ld_in;
    logic st_smooth;
    logic st_dband;
    logic st_mnum;
    logic div_go;
    logic div_force;
    logic st_meas;
    logic st_err;
    logic st_mul1;
    logic st_mul2;
    logic st_num;
    logic st_out;
  } sapf_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic div_done;
  } sapf_sts_t;

endpackage

/* rtl/core/sapf_div.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sapf_div
// Restoring divider, one quotient bit per cycle, with overflow detection
// for quotients that do not fit the quotient width.
// ---------------------------------------------------------------------------
module sapf_div
  import sapf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_QW-1:0] quo,
  output logic              ovf
);

  localparam int unsigned CNT_W = $clog2(DIV_QW + 1);

  logic [DIV_NW-1:0] rem_r;
  logic [DIV_NW-1:0] dsh_r;
  logic [DIV_QW-1:0] quo_r;
  logic              ovf_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [DIV_NW-1:0] den_top;
  logic [DIV_NW-1:0] den_first;
  logic              fits;

  // Divisor aligned to the top quotient bit and one above it
  assign den_top   = DIV_NW'({den, {DIV_QW{1'b0}}});
  assign den_first = DIV_NW'({den, {(DIV_QW-1){1'b0}}});
  assign fits      = (rem_r >= dsh_r);

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIV_QW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift and subtract
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dsh_r <= den_first;
      quo_r <= '0;
      ovf_r <= (num >= den_top);
    end else if (busy_r) begin
      if (fits) begin
        rem_r <= rem_r - dsh_r;
      end
      quo_r <= {quo_r[DIV_QW-2:0], fits};
      dsh_r <= dsh_r >> 1;
    end
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign ovf  = ovf_r;

endmodule

/* rtl/core/sapf_dpath.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sapf_dpath
// Datapath: command timer, smoothing, angle mapping, PD force and the
// result register, stepped by the controller's commands.
// ---------------------------------------------------------------------------
module sapf_dpath
  import sapf_pkg::*;
#(
  parameter int unsigned MAX_ANGLE_DEG = MAX_ANGLE_DEG_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sapf_cfg_t          cfg,
  input  sapf_cmd_t          cmd,
  output sapf_sts_t          sts,
  input  logic               in_has_command,
  input  logic signed [15:0] in_steering_command,
  input  logic signed [15:0] in_raw_axis,
  input  logic [19:0]        in_elapsed_us,
  output logic signed [14:0] out_drive_force,
  output logic signed [15:0] out_target_angle,
  output logic signed [15:0] out_measured_angle
);

  // Angle limit in Q8.8
  localparam logic [14:0]        LIM   = 15'(MAX_ANGLE_DEG * 256);
  localparam logic signed [23:0] MAXS  = 24'(MAX_ANGLE_DEG);
  localparam logic [23:0]        RHALF = 24'd64;

  // State carried from tick to tick
  logic [19:0]        tmr_r;
  logic signed [15:0] held_r;
  logic signed [15:0] smooth_r;
  logic signed [15:0] prev_r;

  // Per-item working registers
  logic [19:0]        dt_r;
  logic signed [16:0] dif_r;
  logic signed [15:0] target_r;
  logic [31:0]        mnum_r;
  logic signed [15:0] meas_r;
  logic signed [16:0] err_r;
  logic signed [16:0] diff_r;
  logic signed [33:0] pe_r;
  logic signed [33:0] dd_r;
  logic signed [54:0] p1_r;
  logic signed [54:0] p2_r;
  logic [DIV_NW-1:0]  fmag_r;
  logic               fneg_r;

  // Result register
  logic signed [14:0] force_out_r;
  logic signed [15:0] target_out_r;
  logic signed [15:0] meas_out_r;

  // Timer and held command
  logic [20:0]        tmr_sum;
  logic [19:0]        tmr_nxt;
  logic signed [15:0] held_nxt;

  always_comb begin
    tmr_sum = {1'b0, tmr_r} + {1'b0, in_elapsed_us};
    if (in_has_command) begin
      tmr_nxt  = '0;
      held_nxt = in_steering_command;
    end else begin
      tmr_nxt  = tmr_sum[20] ? TIMER_MAX : tmr_sum[19:0];
      held_nxt = held_r;
    end
    if (tmr_nxt > cfg.timeout_us) begin
      held_nxt = '0;
    end
  end

  // Smoothing filter, Q15 product sum rounded half up
  logic signed [32:0] sm_sum;
  logic signed [32:0] sm_shift;

  assign sm_sum   = SMOOTH_OLD * 33'(smooth_r) + SMOOTH_NEW * 33'(held_r) + SMOOTH_HALF;
  assign sm_shift = sm_sum >>> 15;

  // Deadband on the smoothed command
  logic [16:0] sm_abs;

  assign sm_abs = smooth_r[15] ? 17'(-17'(smooth_r)) : 17'(smooth_r);

  // Target angle, rounded half away from zero
  logic signed [23:0] tprod;
  logic [23:0]        tmag;
  logic [23:0]        trnd;

  assign tprod = 24'(smooth_r) * MAXS;
  assign tmag  = tprod[23] ? 24'(-tprod) : 24'(tprod);
  assign trnd  = (tmag + RHALF) >> 7;

  // Measured angle numerator: |axis - centre| * limit + half range / 2
  logic [16:0] dmag;

  assign dmag = dif_r[16] ? 17'(-dif_r) : 17'(dif_r);

  // Shared divider
  logic [DIV_NW-1:0] div_num;
  logic [DIV_DW-1:0] div_den;
  logic              div_done;
  logic [DIV_QW-1:0] div_quo;
  logic              div_ovf;

  assign div_num = cmd.div_force ? fmag_r : DIV_NW'(mnum_r);
  assign div_den = cmd.div_force ? {dt_r, 16'd0} : DIV_DW'(cfg.axis_half_range);

  sapf_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_go),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo),
    .ovf   (div_ovf)
  );

  assign sts.div_done = div_done;

  // Measured angle: clamp, sign and inversion
  logic [15:0]        mmag;
  logic               mneg;
  logic signed [15:0] meas_nxt;

  always_comb begin
    if (div_ovf || ({1'b0, div_quo} > {1'b0, LIM})) begin
      mmag = {1'b0, LIM};
    end else begin
      mmag = {1'b0, div_quo};
    end
    mneg = dif_r[16] ^ cfg.invert_wheel;
    if (cfg.axis_half_range == '0) begin
      meas_nxt = '0;
    end else if (mneg) begin
      meas_nxt = -$signed(mmag);
    end else begin
      meas_nxt = $signed(mmag);
    end
  end

  // Force numerator: kp*err*dt - kd*diff*1e6
  logic signed [55:0] num_full;
  logic [55:0]        num_abs;

  assign num_full = 56'(p1_r) - 56'(p2_r);
  assign num_abs  = num_full[55] ? 56'(-num_full) : 56'(num_full);

  // Force saturation and device sign
  logic [13:0]        fsat;
  logic signed [14:0] force_nxt;

  always_comb begin
    if (div_ovf || (div_quo > {1'b0, cfg.force_limit})) begin
      fsat = cfg.force_limit;
    end else begin
      fsat = div_quo[13:0];
    end
    force_nxt = fneg_r ? $signed({1'b0, fsat}) : -$signed({1'b0, fsat});
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmr_r    <= '0;
      held_r   <= '0;
      smooth_r <= '0;
      prev_r   <= '0;
    end else begin
      if (cmd.ld_in) begin
        tmr_r  <= tmr_nxt;
        held_r <= held_nxt;
      end
      if (cmd.st_smooth) begin
        smooth_r <= sm_shift[15:0];
      end else if (cmd.st_dband && (sm_abs < {2'b00, cfg.command_deadband})) begin
        smooth_r <= '0;
      end
      if (cmd.st_err) begin
        prev_r <= meas_r;
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      dt_r  <= (in_elapsed_us <= 20'd1) ? DT_DEFAULT_US : in_elapsed_us;
      dif_r <= 17'(in_raw_axis) - 17'($signed(cfg.axis_center));
    end
    if (cmd.st_mnum) begin
      target_r <= tprod[23] ? -$signed(trnd[15:0]) : $signed(trnd[15:0]);
      mnum_r   <= 32'(dmag * LIM) + 32'(cfg.axis_half_range >> 1);
    end
    if (cmd.st_meas) begin
      meas_r <= meas_nxt;
    end
    if (cmd.st_err) begin
      err_r  <= 17'(target_r) - 17'(meas_r);
      diff_r <= 17'(meas_r) - 17'(prev_r);
    end
    if (cmd.st_mul1) begin
      pe_r <= $signed({1'b0, cfg.prop_gain}) * err_r;
      dd_r <= $signed({1'b0, cfg.deriv_gain}) * diff_r;
    end
    if (cmd.st_mul2) begin
      p1_r <= pe_r * $signed({1'b0, dt_r});
      p2_r <= dd_r * US_PER_S;
    end
    if (cmd.st_num) begin
      fneg_r <= num_full[55];
      fmag_r <= num_abs[DIV_NW-1:0];
    end
    if (cmd.st_out) begin
      force_out_r  <= force_nxt;
      target_out_r <= target_r;
      meas_out_r   <= meas_r;
    end
  end

  assign out_drive_force    = force_out_r;
  assign out_target_angle   = target_out_r;
  assign out_measured_angle = meas_out_r;

endmodule

/* rtl/core/sapf_ctrl.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sapf_ctrl
// Controller: steps one item through the datapath and owns the handshake
// of both channels.
// ---------------------------------------------------------------------------
module sapf_ctrl
  import sapf_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  output sapf_cmd_t cmd,
  input  sapf_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SMOOTH,
    S_DBAND,
    S_MNUM,
    S_MDIV_GO,
    S_MDIV_WAIT,
    S_MEAS,
    S_ERR,
    S_MUL1,
    S_MUL2,
    S_NUM,
    S_FDIV_GO,
    S_FDIV_WAIT,
    S_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid_r || !out_stall;
  assign accept   = (state_r == S_IDLE) && in_valid;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.ld_in = 1'b1;
          state_nxt = S_SMOOTH;
        end
      end
      S_SMOOTH: begin
        cmd.st_smooth = 1'b1;
        state_nxt     = S_DBAND;
      end
      S_DBAND: begin
        cmd.st_dband = 1'b1;
        state_nxt    = S_MNUM;
      end
      S_MNUM: begin
        cmd.st_mnum = 1'b1;
        state_nxt   = S_MDIV_GO;
      end
      S_MDIV_GO: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_MDIV_WAIT;
      end
      S_MDIV_WAIT: begin
        if (sts.div_done) begin
          state_nxt = S_MEAS;
        end
      end
      S_MEAS: begin
        cmd.st_meas = 1'b1;
        state_nxt   = S_ERR;
      end
      S_ERR: begin
        cmd.st_err = 1'b1;
        state_nxt  = S_MUL1;
      end
      S_MUL1: begin
        cmd.st_mul1 = 1'b1;
        state_nxt   = S_MUL2;
      end
      S_MUL2: begin
        cmd.st_mul2 = 1'b1;
        state_nxt   = S_NUM;
      end
      S_NUM: begin
        cmd.st_num = 1'b1;
        state_nxt  = S_FDIV_GO;
      end
      S_FDIV_GO: begin
        cmd.div_go    = 1'b1;
        cmd.div_force = 1'b1;
        state_nxt     = S_FDIV_WAIT;
      end
      S_FDIV_WAIT: begin
        cmd.div_force = 1'b1;
        if (sts.div_done) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        cmd.div_force = 1'b1;
        if (out_free) begin
          cmd.st_out = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cmd.st_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Input held off while busy and while in reset
  assign in_stall  = (state_r != S_IDLE) || !rst_n;
  assign out_valid = out_valid_r;

  // One item at a time: an accepted item closes the input
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input taken while an item is in progress");

  // Divider completion is only expected while waiting for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> (state_r == S_MDIV_WAIT || state_r == S_FDIV_WAIT))
    else $error("divider finished outside a wait state");

  // A loaded result is offered on the next cycle
  a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.st_out |=> out_valid)
    else $error("result loaded but not offered");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !cmd.st_out)
    else $error("result register overwritten while stalled");

endmodule

/* rtl/core/steering_angle_pd_force.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// steering_angle_pd_force
// Steering wheel PD force controller: per control tick, takes an optional
// steering command, the raw axis position and the tick length, and returns
// the device force together with the target and measured angles.
//
// Input channel (in_valid / in_stall): one item per control tick. Result
// channel (out_valid / out_stall): one item per input item, in order.
// Configuration (cfg_valid / cfg_ready, ready whenever out of reset):
// register index and data, to be written by the user only while no item
// is in progress; the block itself does not enforce this. Each item
// passes twice through a shared one-bit-per-cycle divider (angle
// mapping, then force), each pass with its own start step, plus nine
// steps for filtering, multiplication and the result load; the block
// then returns to idle to take the next item.
// Results sit in an output register, so the next item is accepted as soon
// as the previous one is registered; a stalled receiver holds the result
// and, once the following item is finished, holds the block too.
// Reset clears the held command, filter state, previous angle and command
// timer, loads the register defaults, drops out_valid and stalls the input.
// ---------------------------------------------------------------------------
module steering_angle_pd_force
  import sapf_pkg::*;
#(
  parameter int unsigned MAX_ANGLE_DEG = MAX_ANGLE_DEG_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input items
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_has_command,
  input  logic signed [15:0]    in_steering_command,
  input  logic signed [15:0]    in_raw_axis,
  input  logic [19:0]           in_elapsed_us,
  // result items
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [14:0]    out_drive_force,
  output logic signed [15:0]    out_target_angle,
  output logic signed [15:0]    out_measured_angle,
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  sapf_cfg_t cfg_r;
  sapf_cmd_t cmd;
  sapf_sts_t sts;

  // Writes only land out of reset
  assign cfg_ready = rst_n;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.axis_center      <= RST_AXIS_CENTER;
      cfg_r.axis_half_range  <= RST_AXIS_HALF_RANGE;
      cfg_r.prop_gain        <= RST_PROP_GAIN;
      cfg_r.deriv_gain       <= RST_DERIV_GAIN;
      cfg_r.force_limit      <= RST_FORCE_LIMIT;
      cfg_r.command_deadband <= RST_COMMAND_DEADBAND;
      cfg_r.timeout_us       <= RST_TIMEOUT_US;
      cfg_r.invert_wheel     <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AXIS_CENTER:      cfg_r.axis_center      <= cfg_wdata[14:0];
        REG_AXIS_HALF_RANGE:  cfg_r.axis_half_range  <= cfg_wdata[14:0];
        REG_PROP_GAIN:        cfg_r.prop_gain        <= cfg_wdata[15:0];
        REG_DERIV_GAIN:       cfg_r.deriv_gain       <= cfg_wdata[15:0];
        REG_FORCE_LIMIT:      cfg_r.force_limit      <= cfg_wdata[13:0];
        REG_COMMAND_DEADBAND: cfg_r.command_deadband <= cfg_wdata[14:0];
        REG_TIMEOUT_US:       cfg_r.timeout_us       <= cfg_wdata[19:0];
        REG_INVERT_WHEEL:     cfg_r.invert_wheel     <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  sapf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  sapf_dpath #(
    .MAX_ANGLE_DEG (MAX_ANGLE_DEG)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_has_command      (in_has_command),
    .in_steering_command (in_steering_command),
    .in_raw_axis         (in_raw_axis),
    .in_elapsed_us       (in_elapsed_us),
    .out_drive_force     (out_drive_force),
    .out_target_angle    (out_target_angle),
    .out_measured_angle  (out_measured_angle)
  );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Checks steering_angle_pd_force against a cycle-free predictor of the
// command hold and timeout, command smoothing and deadband, axis to angle
// mapping and the saturated PD force. Items are fed from a queue by a
// clocked driver; a clocked monitor compares each result with the oldest
// prediction. The run steps through several register settings, including
// both extremes, under varied sender gaps and receiver stalls.
// ---------------------------------------------------------------------------
module testbench;
  import sapf_pkg::*;

  localparam longint ANGLE_FS   = MAX_ANGLE_DEG_DEF;
  localparam longint ANGLE_LIM  = ANGLE_FS * 256;
  localparam int     STALL_LIM  = 4000;  // cycles with no transfer at all
  localparam int     LONG_HOLD  = 400;   // receiver hold-off, in cycles
  localparam int     DRAIN_WAIT = 100;   // margin beyond the result latency

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic               has_cmd;
    logic signed [15:0] cmd;
    logic signed [15:0] raw;
    logic [19:0]        elapsed;
  } tick_t;

  typedef struct packed {
    logic signed [14:0] drive_force;
    logic signed [15:0] target_angle;
    logic signed [15:0] measured_angle;
  } pd_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_has_command = 1'b0;
  logic signed [15:0] in_steering_command = '0;
  logic signed [15:0] in_raw_axis = '0;
  logic [19:0]        in_elapsed_us = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [14:0] out_drive_force;
  logic signed [15:0] out_target_angle;
  logic signed [15:0] out_measured_angle;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state and register copy
  sapf_cfg_t          model_cfg;
  logic signed [15:0] held_cmd;
  logic signed [15:0] smooth_cmd;
  logic signed [15:0] prev_angle;
  logic [19:0]        cmd_timer;

  tick_t   tick_q[$];
  pd_out_t pd_outputs_q[$];
  tick_t   on_bus;
  pd_out_t got, want;

  idle_mode_t idle_mode = IDLE_NONE;
  int queued_n = 0, accepted_n = 0, checked_n = 0;
  int errors = 0, cfg_writes = 0, phases_n = 0;
  int quiet_cycles = 0;
  logic hold_arm = 1'b0, hold_used = 1'b0;
  int hold_left = 0;

  steering_angle_pd_force DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_has_command     (in_has_command),
    .in_steering_command(in_steering_command),
    .in_raw_axis        (in_raw_axis),
    .in_elapsed_us      (in_elapsed_us),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_drive_force    (out_drive_force),
    .out_target_angle   (out_target_angle),
    .out_measured_angle (out_measured_angle),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR: %s", msg);
  endtask

  // Rounded division, half away from zero; d > 0
  function automatic longint div_round(input longint n, input longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  // One control tick of the controller: updates the predictor state and
  // queues the expected outputs
  task automatic compute_pd_outputs(input tick_t t);
    longint sum, s, tgt, meas, dt, err, diff, num, frc;
    pd_out_t r;
    if (t.has_cmd) begin
      held_cmd  = t.cmd;
      cmd_timer = '0;
    end else begin
      sum = longint'(cmd_timer) + longint'(t.elapsed);
      cmd_timer = (sum > longint'(TIMER_MAX)) ? TIMER_MAX : sum[19:0];
    end
    if (cmd_timer > model_cfg.timeout_us) held_cmd = '0;

    // smoothing, rounded half up, then deadband
    s = (longint'(SMOOTH_OLD) * longint'(smooth_cmd) +
         longint'(SMOOTH_NEW) * longint'(held_cmd) + longint'(SMOOTH_HALF)) >>> 15;
    if ((s < 0 ? -s : s) < longint'(model_cfg.command_deadband)) s = 0;
    smooth_cmd = s[15:0];
    tgt = div_round(s * ANGLE_FS, 128);

    // axis mapping around the centre, clamped, optionally inverted
    if (model_cfg.axis_half_range == '0) meas = 0;
    else begin
      meas = div_round((longint'(t.raw) - longint'($signed(model_cfg.axis_center)))
                       * ANGLE_FS * 256, longint'(model_cfg.axis_half_range));
      if (meas > ANGLE_LIM) meas = ANGLE_LIM;
      if (meas < -ANGLE_LIM) meas = -ANGLE_LIM;
    end
    if (model_cfg.invert_wheel) meas = -meas;

    // PD force; short ticks count as the default tick for the derivative
    dt   = (t.elapsed <= 20'd1) ? longint'(DT_DEFAULT_US) : longint'(t.elapsed);
    err  = tgt - meas;
    diff = meas - longint'(prev_angle);
    prev_angle = meas[15:0];
    num = longint'(model_cfg.prop_gain) * err * dt
        - longint'(model_cfg.deriv_gain) * diff * longint'(US_PER_S);
    frc = num / (65536 * dt);
    if (frc > longint'(model_cfg.force_limit)) frc = longint'(model_cfg.force_limit);
    if (frc < -longint'(model_cfg.force_limit)) frc = -longint'(model_cfg.force_limit);
    frc = -frc;

    r.drive_force    = frc[14:0];
    r.target_angle   = tgt[15:0];
    r.measured_angle = meas[15:0];
    pd_outputs_q.push_back(r);
  endtask

  function automatic logic sender_pause();
    if (idle_mode == IDLE_SEND) return $urandom_range(0, 99) < 47;
    if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 10;
    return 1'b0;
  endfunction

  function automatic logic receiver_pause();
    if (idle_mode == IDLE_RECV) return $urandom_range(0, 99) < 47;
    if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 10;
    return 1'b0;
  endfunction

  // Driver: accepted item goes to the predictor, next item from the queue
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      compute_pd_outputs(on_bus);
      accepted_n++;
    end
    if (rst_n && (!in_valid || !in_stall)) begin
      if (tick_q.size() != 0 && !sender_pause()) begin
        on_bus = tick_q.pop_front();
        in_valid            <= 1'b1;
        in_has_command      <= on_bus.has_cmd;
        in_steering_command <= on_bus.cmd;
        in_raw_axis         <= on_bus.raw;
        in_elapsed_us       <= on_bus.elapsed;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, armed once
  always @(posedge clk) begin
    if (hold_arm && !hold_used) begin
      hold_left <= LONG_HOLD;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_drive_force, out_target_angle, out_measured_angle};
      if (pd_outputs_q.size() == 0) begin
        flag_error($sformatf("unexpected result force %0d target %0d measured %0d",
                             got.drive_force, got.target_angle, got.measured_angle));
      end else begin
        want = pd_outputs_q.pop_front();
        if (got.drive_force !== want.drive_force ||
            got.target_angle !== want.target_angle ||
            got.measured_angle !== want.measured_angle)
          flag_error($sformatf(
            "item %0d: force %0d/%0d target %0d/%0d measured %0d/%0d (exp/got)",
            checked_n, want.drive_force, got.drive_force, want.target_angle,
            got.target_angle, want.measured_angle, got.measured_angle));
        checked_n++;
      end
    end
    out_stall <= (hold_left != 0) || receiver_pause();
  end

  // Watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIM) begin
      $display("Watchdog expired after %0d idle cycles", quiet_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [19:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_AXIS_CENTER:      model_cfg.axis_center      = val[14:0];
      REG_AXIS_HALF_RANGE:  model_cfg.axis_half_range  = val[14:0];
      REG_PROP_GAIN:        model_cfg.prop_gain        = val[15:0];
      REG_DERIV_GAIN:       model_cfg.deriv_gain       = val[15:0];
      REG_FORCE_LIMIT:      model_cfg.force_limit      = val[13:0];
      REG_COMMAND_DEADBAND: model_cfg.command_deadband = val[14:0];
      REG_TIMEOUT_US:       model_cfg.timeout_us       = val[19:0];
      REG_INVERT_WHEEL:     model_cfg.invert_wheel     = val[0];
      default: ;
    endcase
  endtask

  task automatic write_all(input sapf_cfg_t c);
    write_reg(REG_AXIS_CENTER, 20'(c.axis_center));
    write_reg(REG_AXIS_HALF_RANGE, 20'(c.axis_half_range));
    write_reg(REG_PROP_GAIN, 20'(c.prop_gain));
    write_reg(REG_DERIV_GAIN, 20'(c.deriv_gain));
    write_reg(REG_FORCE_LIMIT, 20'(c.force_limit));
    write_reg(REG_COMMAND_DEADBAND, 20'(c.command_deadband));
    write_reg(REG_TIMEOUT_US, c.timeout_us);
    write_reg(REG_INVERT_WHEEL, 20'(c.invert_wheel));
  endtask

  function automatic sapf_cfg_t random_cfg();
    sapf_cfg_t c;
    c.axis_center      = 15'($urandom_range(0, 20000) - 10000);
    c.axis_half_range  = 15'($urandom_range(1000, 32767));
    c.prop_gain        = 16'($urandom);
    c.deriv_gain       = 16'($urandom_range(0, 3000));
    c.force_limit      = 14'($urandom_range(0, 10000));
    c.command_deadband = 15'($urandom_range(0, 3000));
    c.timeout_us       = 20'($urandom_range(20000, 1000000));
    c.invert_wheel     = 1'($urandom);
    return c;
  endfunction

  task automatic queue_tick(input tick_t t);
    tick_q.push_back(t);
    queued_n++;
  endtask

  function automatic tick_t make_tick(input bit h, input int c, input int r, input int e);
    tick_t t;
    t.has_cmd = h;
    t.cmd     = 16'(c);
    t.raw     = 16'(r);
    t.elapsed = 20'(e);
    return t;
  endfunction

  // Mostly plausible ticks near the centre, with full-range values mixed in
  function automatic tick_t random_tick();
    tick_t t;
    int pick;
    t.has_cmd = $urandom_range(0, 99) < 40;
    pick = $urandom_range(0, 9);
    if (pick == 0)      t.cmd = 16'sh7FFF;
    else if (pick == 1) t.cmd = 16'sh8000;
    else                t.cmd = 16'($urandom);
    if ($urandom_range(0, 1))
      t.raw = 16'(int'($signed(model_cfg.axis_center)) + int'($urandom_range(0, 4000)) - 2000);
    else
      t.raw = 16'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0)     t.elapsed = 20'($urandom_range(0, 2));
    else if (pick < 6) t.elapsed = 20'($urandom_range(5000, 20000));
    else if (pick < 8) t.elapsed = 20'($urandom);
    else               t.elapsed = 20'($urandom_range(100000, 1048575));
    return t;
  endfunction

  task automatic drain_phase();
    while (accepted_n != queued_n || checked_n != accepted_n) @(posedge clk);
    phases_n++;
  endtask

  task automatic run_random(input idle_mode_t m, input int n);
    idle_mode = m;
    repeat (n) queue_tick(random_tick());
    drain_phase();
  endtask

  // Stimulus sequence
  initial begin
    model_cfg = '{RST_AXIS_CENTER, RST_AXIS_HALF_RANGE, RST_PROP_GAIN, RST_DERIV_GAIN,
                  RST_FORCE_LIMIT, RST_COMMAND_DEADBAND, RST_TIMEOUT_US, 1'b0};
    held_cmd   = '0;
    smooth_cmd = '0;
    prev_angle = '0;
    cmd_timer  = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed ticks at reset settings: extremes, short ticks, timeout,
    // timer saturation, deadband and axis clamping
    idle_mode = IDLE_NONE;
    queue_tick(make_tick(1, 32767, 0, 10000));
    queue_tick(make_tick(1, -32768, 32767, 10000));
    queue_tick(make_tick(0, 0, -32768, 0));
    queue_tick(make_tick(0, 0, 10000, 1));
    queue_tick(make_tick(0, 0, -10000, 2));
    queue_tick(make_tick(0, 0, 0, 1000000));
    queue_tick(make_tick(0, 0, 0, 1048575));
    queue_tick(make_tick(0, 0, 0, 1048575));
    queue_tick(make_tick(1, 500, 0, 10000));
    queue_tick(make_tick(1, 500, 5, 10000));
    queue_tick(make_tick(1, -32768, -5000, 10000));
    queue_tick(make_tick(0, 12345, -5000, 500000));
    queue_tick(make_tick(0, 0, 0, 1));
    queue_tick(make_tick(1, 16384, 3000, 10000));
    queue_tick(make_tick(0, 0, 3000, 10000));
    queue_tick(make_tick(1, 0, 0, 10000));
    queue_tick(make_tick(1, -1, -1, 20000));
    queue_tick(make_tick(1, 32767, -32768, 1000000));
    drain_phase();

    write_all(random_cfg());
    run_random(IDLE_SEND, 90);

    // Every register at its largest value
    write_all('{15'h3FFF, 15'h7FFF, 16'hFFFF, 16'hFFFF, 14'h3FFF, 15'h7FFF,
                20'hFFFFF, 1'b1});
    run_random(IDLE_RECV, 70);

    // Every register at its smallest value: zero half range, zero deadband
    write_all('{15'h4000, 15'd0, 16'd0, 16'd0, 14'd0, 15'd0, 20'd0, 1'b0});
    run_random(IDLE_BOTH, 60);

    // Narrow half range with a long receiver hold-off to fill the block
    write_all('{15'd0, 15'd1, 16'hFFFF, 16'd0, 14'h3FFF, 15'd0, 20'd1000000, 1'b1});
    idle_mode = IDLE_NONE;
    @(posedge clk);
    hold_arm <= 1'b1;
    run_random(IDLE_NONE, 100);

    write_all(random_cfg());
    run_random(IDLE_BOTH, 90);
    write_all(random_cfg());
    run_random(IDLE_NONE, 90);

    repeat (DRAIN_WAIT) @(posedge clk);
    if (pd_outputs_q.size() != 0)
      flag_error($sformatf("%0d results never arrived", pd_outputs_q.size()));

    $display("Ran %0d ticks over %0d phases with %0d register writes;",
             accepted_n, phases_n, cfg_writes);
    $display("%0d results compared, %0d mismatches", checked_n, errors);
    if (errors == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
